[design/bcdcpu_pkg.sv]
// shared types, opcode names, mask table and decoder of the serial bcd processor
package bcdcpu_pkg;

	localparam int NUM_DIGITS = 11;
	localparam int NUM_MASKS  = 16;
	localparam int POS_W      = 4;

	localparam logic [31:0] OPS_WITH_K = 32'h3C07AA66;
	localparam logic [3:0]  DIG_OFF    = 4'hF;
	localparam logic [3:0]  LAST_POS   = 4'd10;
	localparam logic [3:0]  LAST_TIME  = 4'd9;

	// instruction classes
	localparam logic [1:0] CLS_BR_NC = 2'd0;
	localparam logic [1:0] CLS_BR_C  = 2'd1;
	localparam logic [1:0] CLS_MISC  = 2'd2;
	localparam logic [1:0] CLS_DIGIT = 2'd3;

	// digit opcodes
	localparam logic [4:0] OP_ADD_AB_A = 5'd0;
	localparam logic [4:0] OP_ADD_AK_A = 5'd1;
	localparam logic [4:0] OP_ADD_AK_C = 5'd2;
	localparam logic [4:0] OP_ALT3     = 5'd3;
	localparam logic [4:0] OP_CPY_B_C  = 5'd4;
	localparam logic [4:0] OP_ADD_CK_A = 5'd5;
	localparam logic [4:0] OP_ADD_CK_B = 5'd6;
	localparam logic [4:0] OP_SUB_AB_A = 5'd7;
	localparam logic [4:0] OP_SUB_AB_C = 5'd8;
	localparam logic [4:0] OP_SUB_AK_A = 5'd9;
	localparam logic [4:0] OP_SUB_CB_C = 5'd10;
	localparam logic [4:0] OP_SUB_CK_C = 5'd11;
	localparam logic [4:0] OP_CMP_AB   = 5'd12;
	localparam logic [4:0] OP_CMP_AK   = 5'd13;
	localparam logic [4:0] OP_CMP_CB   = 5'd14;
	localparam logic [4:0] OP_CMP_CK   = 5'd15;
	localparam logic [4:0] OP_CPY_K_A  = 5'd16;
	localparam logic [4:0] OP_CPY_K_B  = 5'd17;
	localparam logic [4:0] OP_CPY_K_C  = 5'd18;
	localparam logic [4:0] OP_SWAP_AB  = 5'd19;
	localparam logic [4:0] OP_SHL_A    = 5'd20;
	localparam logic [4:0] OP_SHL_B    = 5'd21;
	localparam logic [4:0] OP_SHL_C    = 5'd22;
	localparam logic [4:0] OP_SHR_A    = 5'd23;
	localparam logic [4:0] OP_SHR_B    = 5'd24;
	localparam logic [4:0] OP_SHR_C    = 5'd25;
	localparam logic [4:0] OP_WAITNO   = 5'd26;
	localparam logic [4:0] OP_ALT27    = 5'd27;
	localparam logic [4:0] OP_ALT28    = 5'd28;
	localparam logic [4:0] OP_ADD_CK_C = 5'd29;
	localparam logic [4:0] OP_ALT30    = 5'd30;
	localparam logic [4:0] OP_ALT31    = 5'd31;

	// flag and key opcodes
	localparam logic [4:0] FOP_BKEY  = 5'd18;
	localparam logic [4:0] FOP_SET_B = 5'd19;
	localparam logic [4:0] FOP_SET_A = 5'd20;
	localparam logic [4:0] FOP_SYNC  = 5'd21;
	localparam logic [4:0] FOP_SCAN  = 5'd22;
	localparam logic [4:0] FOP_CLR_B = 5'd23;
	localparam logic [4:0] FOP_CLR_A = 5'd24;
	localparam logic [4:0] FOP_TST_B = 5'd25;
	localparam logic [4:0] FOP_TST_A = 5'd26;
	localparam logic [4:0] FOP_FLP_B = 5'd27;
	localparam logic [4:0] FOP_FLP_A = 5'd28;
	localparam logic [4:0] FOP_CMP   = 5'd29;
	localparam logic [4:0] FOP_SWAP  = 5'd31;

	// one hex digit per position, position 0 leftmost, F marks a disabled position
	localparam logic [43:0] MASK_TBL [2][NUM_MASKS] = '{
		'{44'hFFFFFFFFFF7, 44'hFFFFFFFFF4F, 44'hFFFFFFFF1FF, 44'hFFFFFFF0FFF,
		  44'hFFFFFF0FFFF, 44'hFFFFF0FFFFF, 44'hFFFF0FFFFFF, 44'hF0FFFFFFFFF,
		  44'h1FFFFFFFFFF, 44'hFFFFFFFF000, 44'h01FFFFFFFFF, 44'h000000001FF,
		  44'h000000000FF, 44'hFFFFFFFFF01, 44'hFFFFFFFFF00, 44'h00000000000},
		'{44'h00000000000, 44'h5FFFFFFFFFF, 44'hFF00FFFFFFF, 44'hFFFF1FFFFFF,
		  44'hFFFF0000000, 44'hFFFFFFFFFF1, 44'hFF01FFFFFFF, 44'hF5FFFFFFFFF,
		  44'h000000FFFFF, 44'h0001FFFFFFF, 44'hFFFF0000001, 44'hFFFFF1FFFFF,
		  44'hFFFF00005FF, 44'hFFFF00001FF, 44'hFFFF4FFFFFF, 44'hFFFF0FFFFFF}
	};

	typedef enum logic [3:0] {
		K_NOP, K_ADD, K_SUB, K_COPY, K_SWAP, K_SHL, K_SHR,
		K_FSET, K_FCLR, K_FFLIP, K_FTEST, K_FCMP, K_FSWAP
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  x_is_c;
		logic  y_is_k;
		logic  dest_a;
		logic  dest_b;
		logic  dest_c;
		logic  flag_a;
		logic  hex;
		logic  use_k;
	} ctl_t;

	function automatic logic [3:0] mask_digit(logic alt, logic [3:0] m, logic [3:0] pos);
		logic [3:0] sh;
		sh = LAST_POS - pos;
		return MASK_TBL[alt][m][{sh, 2'b00} +: 4];
	endfunction

	function automatic ctl_t decode(logic [10:0] w, logic alt);
		ctl_t c;
		logic [4:0] op;
		op = w[8:4];
		c = '{kind: K_NOP, default: 1'b0};
		if (w[10:9] == CLS_DIGIT) begin
			c.use_k = OPS_WITH_K[op];
			case (op)
				OP_ADD_AB_A: begin c.kind = K_ADD; c.dest_a = 1'b1; end
				OP_ADD_AK_A, OP_WAITNO, OP_ADD_CK_A, OP_ADD_AK_C, OP_ADD_CK_B,
				OP_ADD_CK_C: begin
					c.kind   = K_ADD;
					c.y_is_k = 1'b1;
					c.x_is_c = (op == OP_ADD_CK_A) || (op == OP_ADD_CK_B) ||
						(op == OP_ADD_CK_C);
					c.dest_a = (op == OP_ADD_AK_A) || (op == OP_WAITNO) ||
						(op == OP_ADD_CK_A);
					c.dest_b = (op == OP_ADD_CK_B);
					c.dest_c = (op == OP_ADD_AK_C) || (op == OP_ADD_CK_C);
				end
				OP_ALT3: begin
					if (alt) begin
						c.kind = K_ADD; c.x_is_c = 1'b1; c.dest_b = 1'b1;
					end else begin
						c.kind = K_COPY; c.dest_a = 1'b1;
					end
				end
				OP_CPY_B_C: begin c.kind = K_COPY; c.dest_c = 1'b1; end
				OP_SUB_AB_A: begin c.kind = K_SUB; c.dest_a = 1'b1; end
				OP_SUB_AB_C: begin c.kind = K_SUB; c.dest_c = 1'b1; end
				OP_SUB_AK_A: begin c.kind = K_SUB; c.y_is_k = 1'b1; c.dest_a = 1'b1; end
				OP_SUB_CB_C: begin c.kind = K_SUB; c.x_is_c = 1'b1; c.dest_c = 1'b1; end
				OP_SUB_CK_C: begin
					c.kind = K_SUB; c.x_is_c = 1'b1; c.y_is_k = 1'b1; c.dest_c = 1'b1;
				end
				OP_CMP_AB: c.kind = K_SUB;
				OP_CMP_AK: begin c.kind = K_SUB; c.y_is_k = 1'b1; end
				OP_CMP_CB: begin c.kind = K_SUB; c.x_is_c = 1'b1; end
				OP_CMP_CK: begin c.kind = K_SUB; c.x_is_c = 1'b1; c.y_is_k = 1'b1; end
				OP_CPY_K_A: begin c.kind = K_COPY; c.y_is_k = 1'b1; c.dest_a = 1'b1; end
				OP_CPY_K_B: begin c.kind = K_COPY; c.y_is_k = 1'b1; c.dest_b = 1'b1; end
				OP_CPY_K_C: begin c.kind = K_COPY; c.y_is_k = 1'b1; c.dest_c = 1'b1; end
				OP_SWAP_AB: c.kind = K_SWAP;
				OP_SHL_A: begin c.kind = K_SHL; c.dest_a = 1'b1; end
				OP_SHL_B: begin c.kind = K_SHL; c.dest_b = 1'b1; end
				OP_SHL_C: begin c.kind = K_SHL; c.dest_c = 1'b1; end
				OP_SHR_A: begin c.kind = K_SHR; c.dest_a = 1'b1; end
				OP_SHR_B: begin c.kind = K_SHR; c.dest_b = 1'b1; end
				OP_SHR_C: begin c.kind = K_SHR; c.dest_c = 1'b1; end
				OP_ALT27: begin
					if (alt) begin
						c.kind = K_SUB; c.x_is_c = 1'b1; c.dest_a = 1'b1;
					end else begin
						c.kind = K_ADD; c.y_is_k = 1'b1; c.dest_a = 1'b1; c.hex = 1'b1;
					end
				end
				OP_ALT28: begin
					if (alt) begin
						c.kind = K_SUB; c.x_is_c = 1'b1; c.y_is_k = 1'b1; c.dest_b = 1'b1;
					end else begin
						c.kind = K_SUB; c.y_is_k = 1'b1; c.dest_a = 1'b1; c.hex = 1'b1;
					end
				end
				OP_ALT30: begin
					if (alt) begin
						c.kind = K_ADD; c.dest_c = 1'b1;
					end
				end
				default: begin
					if (alt) begin
						c.kind = K_ADD; c.x_is_c = 1'b1; c.dest_c = 1'b1;
					end
				end
			endcase
		end else if (w[10:9] == CLS_MISC && w[8]) begin
			case (op)
				FOP_SET_B: c.kind = K_FSET;
				FOP_SET_A: begin c.kind = K_FSET; c.flag_a = 1'b1; end
				FOP_CLR_B: c.kind = K_FCLR;
				FOP_CLR_A: begin c.kind = K_FCLR; c.flag_a = 1'b1; end
				FOP_TST_B: c.kind = K_FTEST;
				FOP_TST_A: begin c.kind = K_FTEST; c.flag_a = 1'b1; end
				FOP_FLP_B: c.kind = K_FFLIP;
				FOP_FLP_A: begin c.kind = K_FFLIP; c.flag_a = 1'b1; end
				FOP_CMP:   c.kind = K_FCMP;
				FOP_SWAP:  c.kind = K_FSWAP;
				default:   c.kind = K_NOP;
			endcase
		end
		return c;
	endfunction

endpackage

[design/bcdcpu_digit_alu.sv]
// one-digit decimal or hex adder and subtractor with carry
module bcdcpu_digit_alu (
	input  logic [3:0] x,
	input  logic [3:0] y,
	input  logic       cin,
	input  logic       sub,
	input  logic       hex,
	output logic [3:0] d,
	output logic       cout
);
	logic [4:0] sum;
	logic [4:0] need;
	logic [3:0] diff;
	logic       neg;

	always_comb begin
		sum  = {1'b0, x} + {1'b0, y} + {4'b0, cin};
		need = {1'b0, y} + {4'b0, cin};
		neg  = {1'b0, x} < need;
		diff = x - y - {3'b0, cin};
		if (sub) begin
			cout = neg;
			// borrow adds ten in decimal, sixteen vanishes modulo sixteen
			d    = (neg && !hex) ? diff + 4'd10 : diff;
		end else if (hex) begin
			cout = sum[4];
			d    = sum[3:0];
		end else begin
			cout = sum >= 5'd10;
			d    = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
		end
	end
endmodule

[design/bcd_calculator_cpu_step.sv]
// Executes one 11-bit instruction of an eleven-digit serial BCD calculator processor per
// transaction. The digit registers and flag registers rotate past a tap at one end (the
// other end for right shifts), one digit per clock, through a single 4-bit adder: the
// eleven digits go round first, then the finish state settles the condition bit, the program
// address and the result register. A new transaction is taken only when the block is idle,
// so it cannot take a new one before the last is through; the result register holds its
// transaction until taken and a stalled result holds the block in its finish state. The
// variant register is written directly.
module bcd_calculator_cpu_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        variant_we,
	input  logic        variant_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [10:0] instr_word,
	input  logic        key_n,
	input  logic        key_o,
	input  logic [3:0]  read_position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  next_address,
	output logic        carry_flag,
	output logic [3:0]  digit_time,
	output logic [3:0]  read_digit
);
	import bcdcpu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t       state_q;
	logic         variant_q;
	logic [3:0]   a_q [NUM_DIGITS];
	logic [3:0]   b_q [NUM_DIGITS];
	logic [3:0]   c_q [NUM_DIGITS];
	logic [NUM_DIGITS-1:0] fa_q;
	logic [NUM_DIGITS-1:0] fb_q;
	logic         cond_q;
	logic [8:0]   pc_q;
	logic [3:0]   dc_q;
	logic [10:0]  w_q;
	logic         kn_q;
	logic         ko_q;
	logic [3:0]   rpos_q;
	ctl_t         ctl_q;
	logic [3:0]   pos_q;
	logic         cy_q;
	logic         acc_q;
	logic [3:0]   sh_q;
	logic         out_valid_q;
	logic [8:0]   next_address_q;
	logic         carry_flag_q;
	logic [3:0]   digit_time_q;
	logic [3:0]   read_digit_q;

	ctl_t         ctl_in;
	logic         rev;
	logic [3:0]   tap;
	logic [3:0]   mdig;
	logic         en;
	logic [3:0]   kd;
	logic [3:0]   a_t, b_t, c_t;
	logic         fa_t, fb_t, fs_t;
	logic [3:0]   x, y, d;
	logic         cout;
	logic [3:0]   ra, rb, rc;
	logic         rfa, rfb;
	logic         do_fin;
	logic [8:0]   here, nxt;
	logic         cond_new;
	logic         keys;
	logic         not_last;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign next_address = next_address_q;
	assign carry_flag = carry_flag_q;
	assign digit_time = digit_time_q;
	assign read_digit = read_digit_q;

	assign ctl_in = decode(instr_word, variant_q);

	// right shift walks from the most significant digit, everything else from the least
	assign rev  = (ctl_q.kind == K_SHR);
	assign tap  = rev ? 4'd0 : LAST_POS;
	assign mdig = mask_digit(variant_q, w_q[3:0], pos_q);
	assign en   = (mdig != DIG_OFF);
	assign kd   = ctl_q.use_k ? mdig : 4'd0;
	assign a_t  = a_q[tap];
	assign b_t  = b_q[tap];
	assign c_t  = c_q[tap];
	assign fa_t = fa_q[tap];
	assign fb_t = fb_q[tap];
	assign fs_t = ctl_q.flag_a ? fa_t : fb_t;
	assign x    = ctl_q.x_is_c ? c_t : a_t;
	assign y    = ctl_q.y_is_k ? kd : b_t;

	bcdcpu_digit_alu u_alu (
		.x    (x),
		.y    (y),
		.cin  (cy_q),
		.sub  (ctl_q.kind == K_SUB),
		.hex  (ctl_q.hex),
		.d    (d),
		.cout (cout)
	);

	always_comb begin
		ra  = a_t;
		rb  = b_t;
		rc  = c_t;
		rfa = fa_t;
		rfb = fb_t;
		if (en) begin
			case (ctl_q.kind)
				K_ADD, K_SUB: begin
					if (ctl_q.dest_a) ra = d;
					if (ctl_q.dest_b) rb = d;
					if (ctl_q.dest_c) rc = d;
				end
				K_COPY: begin
					if (ctl_q.dest_a) ra = y;
					if (ctl_q.dest_b) rb = y;
					if (ctl_q.dest_c) rc = y;
				end
				K_SWAP: begin
					ra = b_t;
					rb = a_t;
				end
				K_SHL, K_SHR: begin
					if (ctl_q.dest_a) ra = sh_q;
					if (ctl_q.dest_b) rb = sh_q;
					if (ctl_q.dest_c) rc = sh_q;
				end
				K_FSET, K_FCLR, K_FFLIP: begin
					if (ctl_q.flag_a) rfa = (ctl_q.kind == K_FSET) ||
						((ctl_q.kind == K_FFLIP) && !fa_t);
					else rfb = (ctl_q.kind == K_FSET) ||
						((ctl_q.kind == K_FFLIP) && !fb_t);
				end
				K_FSWAP: begin
					rfa = fb_t;
					rfb = fa_t;
				end
				default: ;
			endcase
		end
	end

	// condition bit and next address, settled once all digits have gone round
	always_comb begin
		here     = pc_q;
		nxt      = pc_q + 9'd1;
		cond_new = cond_q;
		keys     = kn_q || ko_q;
		not_last = (dc_q != LAST_TIME);
		case (ctl_q.kind)
			K_ADD, K_SUB: cond_new = ctl_q.hex ? 1'b0 : (cond_q || cy_q);
			K_FTEST, K_FCMP: cond_new = cond_q || acc_q;
			default: ;
		endcase
		case (w_q[10:9])
			CLS_DIGIT: begin
				if (w_q[8:4] == OP_WAITNO && !kn_q && not_last) nxt = here;
			end
			CLS_MISC: begin
				if (w_q[8]) begin
					case (w_q[8:4])
						FOP_BKEY: nxt = keys ? w_q[8:0] : here;
						FOP_SYNC: begin
							if (not_last) nxt = here;
							cond_new = 1'b0;
						end
						FOP_SCAN: begin
							cond_new = keys;
							if (!keys && not_last) nxt = here;
						end
						default: ;
					endcase
				end else begin
					if (!w_q[7] && ko_q) nxt = w_q[8:0];
					cond_new = 1'b0;
				end
			end
			CLS_BR_NC: begin
				if (!cond_q) nxt = w_q[8:0];
				cond_new = 1'b0;
			end
			default: begin
				if (cond_q) nxt = w_q[8:0];
				cond_new = 1'b0;
			end
		endcase
	end

	assign do_fin = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			variant_q   <= 1'b0;
			fa_q        <= '0;
			fb_q        <= '0;
			cond_q      <= 1'b0;
			pc_q        <= '0;
			dc_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
				c_q[i] <= '0;
			end
		end else begin
			if (variant_we) variant_q <= variant_wdata;
			if (do_fin) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_RUN;
				end
				S_RUN: begin
					// rotate every register one place through the tap
					if (rev) begin
						for (int i = 0; i < NUM_DIGITS - 1; i++) begin
							a_q[i]  <= a_q[i+1];
							b_q[i]  <= b_q[i+1];
							c_q[i]  <= c_q[i+1];
							fa_q[i] <= fa_q[i+1];
							fb_q[i] <= fb_q[i+1];
						end
						a_q[NUM_DIGITS-1]  <= ra;
						b_q[NUM_DIGITS-1]  <= rb;
						c_q[NUM_DIGITS-1]  <= rc;
						fa_q[NUM_DIGITS-1] <= rfa;
						fb_q[NUM_DIGITS-1] <= rfb;
					end else begin
						for (int i = 1; i < NUM_DIGITS; i++) begin
							a_q[i]  <= a_q[i-1];
							b_q[i]  <= b_q[i-1];
							c_q[i]  <= c_q[i-1];
							fa_q[i] <= fa_q[i-1];
							fb_q[i] <= fb_q[i-1];
						end
						a_q[0]  <= ra;
						b_q[0]  <= rb;
						c_q[0]  <= rc;
						fa_q[0] <= rfa;
						fb_q[0] <= rfb;
					end
					if ((rev && pos_q == LAST_POS) || (!rev && pos_q == 4'd0))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (do_fin) begin
						state_q     <= S_IDLE;
						cond_q      <= cond_new;
						pc_q        <= nxt;
						dc_q        <= (dc_q >= LAST_TIME) ? 4'd0 : dc_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			w_q    <= instr_word;
			kn_q   <= key_n;
			ko_q   <= key_o;
			rpos_q <= read_position;
			ctl_q  <= ctl_in;
			pos_q  <= (ctl_in.kind == K_SHR) ? 4'd0 : LAST_POS;
			cy_q   <= 1'b0;
			acc_q  <= 1'b0;
			sh_q   <= '0;
		end else if (state_q == S_RUN) begin
			pos_q <= rev ? pos_q + 4'd1 : pos_q - 4'd1;
			if (en) begin
				if (ctl_q.kind == K_ADD || ctl_q.kind == K_SUB) cy_q <= cout;
				if (ctl_q.kind == K_FTEST && fs_t) acc_q <= 1'b1;
				if (ctl_q.kind == K_FCMP && (fa_t != fb_t)) acc_q <= 1'b1;
				if (ctl_q.dest_a) sh_q <= a_t;
				else if (ctl_q.dest_b) sh_q <= b_t;
				else sh_q <= c_t;
			end
		end
		if (do_fin) begin
			next_address_q <= nxt;
			carry_flag_q   <= cond_new;
			digit_time_q   <= (dc_q >= LAST_TIME) ? 4'd0 : dc_q + 4'd1;
			read_digit_q   <= (rpos_q <= LAST_POS) ? a_q[rpos_q] : 4'd0;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (pos_q <= LAST_POS))
		else $error("digit position out of range");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_fin |=> out_valid_q)
		else $error("finished transaction not presented");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (digit_time_q <= LAST_TIME))
		else $error("digit time out of range");

	a_run_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_RUN))
		else $error("accepted transaction did not start");
endmodule

[sim/bcd_step_checker.sv]
// checker: predicts each instruction step of the serial bcd processor and compares results
module bcd_step_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        variant_we,
	input  logic        variant_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [10:0] instr_word,
	input  logic        key_n,
	input  logic        key_o,
	input  logic [3:0]  read_position,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [8:0]  next_address,
	input  logic        carry_flag,
	input  logic [3:0]  digit_time,
	input  logic [3:0]  read_digit,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bcdcpu_pkg::*;

	typedef struct packed {
		logic [8:0] addr;
		logic       cy;
		logic [3:0] dtime;
		logic [3:0] digit;
	} step_result_t;

	typedef logic [3:0] digits_t [NUM_DIGITS];
	typedef logic       flags_t  [NUM_DIGITS];

	step_result_t step_q[$];
	logic        alt_mode;
	digits_t     ra, rb, rc, rk, rscr;
	flags_t      fa, fb;
	logic        cond;
	logic [8:0]  pc;
	logic [3:0]  dcnt;
	logic        en [NUM_DIGITS];

	assign pending = step_q.size();

	function automatic void load_enables(logic [3:0] m, logic use_k);
		logic [3:0] d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			d = MASK_TBL[alt_mode][m][(NUM_DIGITS - 1 - i) * 4 +: 4];
			en[i] = (d != DIG_OFF);
			rk[i] = (en[i] && use_k) ? d : 4'd0;
		end
	endfunction

	function automatic void bcd_add(digits_t x, digits_t y, ref digits_t d, input logic hex);
		int r;
		int cy;
		cy = 0;
		for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
			if (!en[i]) continue;
			r = x[i] + y[i] + cy;
			cy = 0;
			if (!hex && r >= 10) begin r -= 10; cy = 1; end
			else if (hex && r >= 16) begin r -= 16; cy = 1; end
			d[i] = r[3:0];
		end
		if (cy != 0) cond = 1'b1;
	endfunction

	function automatic void bcd_sub(digits_t x, digits_t y, ref digits_t d, input logic hex);
		int r;
		int bw;
		bw = 0;
		for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
			if (!en[i]) continue;
			r = int'(x[i]) - int'(y[i]) - bw;
			bw = 0;
			if (r < 0) begin r += hex ? 16 : 10; bw = 1; end
			d[i] = r[3:0];
		end
		if (bw != 0) cond = 1'b1;
	endfunction

	function automatic void masked_copy(digits_t s, ref digits_t d);
		for (int i = 0; i < NUM_DIGITS; i++)
			if (en[i]) d[i] = s[i];
	endfunction

	function automatic void shift_digits(ref digits_t r, input logic leftward);
		logic [3:0] c, t;
		int j;
		c = 4'd0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			j = leftward ? NUM_DIGITS - 1 - i : i;
			if (en[j]) begin t = r[j]; r[j] = c; c = t; end
		end
	endfunction

	function automatic void write_flags(ref flags_t f, input int how);
		for (int i = 0; i < NUM_DIGITS; i++)
			if (en[i]) f[i] = (how == 2) ? ~f[i] : how[0];
	endfunction

	function automatic step_result_t execute_word(logic [10:0] w, logic kn, logic ko,
			logic [3:0] rpos);
		logic [1:0] cls;
		logic [4:0] op;
		logic [8:0] here, nxt;
		logic t;
		step_result_t res;
		cls = w[10:9];
		op = w[8:4];
		here = pc;
		nxt = pc + 9'd1;
		load_enables(w[3:0], cls == CLS_DIGIT && OPS_WITH_K[op]);
		if (cls == CLS_DIGIT) begin
			case (op)
				OP_ADD_AB_A: bcd_add(ra, rb, ra, 1'b0);
				OP_ADD_AK_A: bcd_add(ra, rk, ra, 1'b0);
				OP_ADD_AK_C: bcd_add(ra, rk, rc, 1'b0);
				OP_ALT3: if (alt_mode) bcd_add(rc, rb, rb, 1'b0); else masked_copy(rb, ra);
				OP_CPY_B_C: masked_copy(rb, rc);
				OP_ADD_CK_A: bcd_add(rc, rk, ra, 1'b0);
				OP_ADD_CK_B: bcd_add(rc, rk, rb, 1'b0);
				OP_SUB_AB_A: bcd_sub(ra, rb, ra, 1'b0);
				OP_SUB_AB_C: bcd_sub(ra, rb, rc, 1'b0);
				OP_SUB_AK_A: bcd_sub(ra, rk, ra, 1'b0);
				OP_SUB_CB_C: bcd_sub(rc, rb, rc, 1'b0);
				OP_SUB_CK_C: bcd_sub(rc, rk, rc, 1'b0);
				OP_CMP_AB: bcd_sub(ra, rb, rscr, 1'b0);
				OP_CMP_AK: bcd_sub(ra, rk, rscr, 1'b0);
				OP_CMP_CB: bcd_sub(rc, rb, rscr, 1'b0);
				OP_CMP_CK: bcd_sub(rc, rk, rscr, 1'b0);
				OP_CPY_K_A: masked_copy(rk, ra);
				OP_CPY_K_B: masked_copy(rk, rb);
				OP_CPY_K_C: masked_copy(rk, rc);
				OP_SWAP_AB:
					for (int i = 0; i < NUM_DIGITS; i++)
						if (en[i]) begin
							rscr[i] = ra[i]; ra[i] = rb[i]; rb[i] = rscr[i];
						end
				OP_SHL_A: shift_digits(ra, 1'b1);
				OP_SHL_B: shift_digits(rb, 1'b1);
				OP_SHL_C: shift_digits(rc, 1'b1);
				OP_SHR_A: shift_digits(ra, 1'b0);
				OP_SHR_B: shift_digits(rb, 1'b0);
				OP_SHR_C: shift_digits(rc, 1'b0);
				OP_WAITNO: begin
					bcd_add(ra, rk, ra, 1'b0);
					if (!kn && dcnt != LAST_TIME) nxt = here;
				end
				OP_ALT27:
					if (alt_mode) bcd_sub(rc, rb, ra, 1'b0);
					else begin bcd_add(ra, rk, ra, 1'b1); cond = 1'b0; end
				OP_ALT28:
					if (alt_mode) bcd_sub(rc, rk, rb, 1'b0);
					else begin bcd_sub(ra, rk, ra, 1'b1); cond = 1'b0; end
				OP_ADD_CK_C: bcd_add(rc, rk, rc, 1'b0);
				OP_ALT30: if (alt_mode) bcd_add(ra, rb, rc, 1'b0);
				default: if (alt_mode) bcd_add(rc, rb, rc, 1'b0);
			endcase
		end else if (cls == CLS_MISC && w[8]) begin
			case (op)
				FOP_BKEY: nxt = (kn || ko) ? w[8:0] : here;
				FOP_SET_B: write_flags(fb, 1);
				FOP_SET_A: write_flags(fa, 1);
				FOP_SYNC: begin
					if (dcnt != LAST_TIME) nxt = here;
					cond = 1'b0;
				end
				FOP_SCAN:
					if (kn || ko) cond = 1'b1;
					else begin
						cond = 1'b0;
						if (dcnt != LAST_TIME) nxt = here;
					end
				FOP_CLR_B: write_flags(fb, 0);
				FOP_CLR_A: write_flags(fa, 0);
				FOP_TST_B: for (int i = 0; i < NUM_DIGITS; i++) if (en[i] && fb[i]) cond = 1'b1;
				FOP_TST_A: for (int i = 0; i < NUM_DIGITS; i++) if (en[i] && fa[i]) cond = 1'b1;
				FOP_FLP_B: write_flags(fb, 2);
				FOP_FLP_A: write_flags(fa, 2);
				FOP_CMP:
					for (int i = 0; i < NUM_DIGITS; i++) if (en[i] && fa[i] != fb[i]) cond = 1'b1;
				FOP_SWAP:
					for (int i = 0; i < NUM_DIGITS; i++)
						if (en[i]) begin t = fa[i]; fa[i] = fb[i]; fb[i] = t; end
				default: ;
			endcase
		end else if (cls == CLS_BR_NC) begin
			if (!cond) nxt = w[8:0];
			cond = 1'b0;
		end else if (cls == CLS_BR_C) begin
			if (cond) nxt = w[8:0];
			cond = 1'b0;
		end else if (w[8:7] == 2'b00) begin
			if (ko) nxt = w[8:0];
			cond = 1'b0;
		end else if (w[8:7] == 2'b01) begin
			cond = 1'b0;
		end
		pc = nxt;
		dcnt = (dcnt >= LAST_TIME) ? 4'd0 : dcnt + 4'd1;
		res.addr = pc;
		res.cy = cond;
		res.dtime = dcnt;
		res.digit = (rpos <= LAST_POS) ? ra[rpos] : 4'd0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			alt_mode <= 1'b0;
			fail_count <= 0;
			step_q.delete();
			cond = 1'b0;
			pc = '0;
			dcnt = '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				ra[i] = '0; rb[i] = '0; rc[i] = '0; rscr[i] = '0; fa[i] = 1'b0; fb[i] = 1'b0;
			end
		end else begin
			if (variant_we)
				alt_mode <= variant_wdata;
			if (in_valid && !in_stall)
				step_q.push_back(execute_word(instr_word, key_n, key_o, read_position));
			if (out_valid && !out_stall) begin
				if (step_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction addr=%0d", next_address);
					fail_count <= fail_count + 1;
				end else begin
					want = step_q.pop_front();
					if (want != {next_address, carry_flag, digit_time, read_digit}) begin
						if (fail_count < 10)
							$display("mismatch: expected addr=%0d c=%0d t=%0d d=%0d, got %0d %0d %0d %0d",
								want.addr, want.cy, want.dtime, want.digit,
								next_address, carry_flag, digit_time, read_digit);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[sim/tb_top.sv]
// stimulus and verdict for the serial bcd processor step block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bcdcpu_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        variant_we = 1'b0;
	logic        variant_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [10:0] instr_word = '0;
	logic        key_n = 1'b0;
	logic        key_o = 1'b0;
	logic [3:0]  read_position = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [8:0]  next_address;
	logic        carry_flag;
	logic [3:0]  digit_time;
	logic [3:0]  read_digit;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          steps_sent = 0;
	int          stall_mode = 0;

	localparam int WATCHDOG = 20000;

	always #5 clk = ~clk;

	bcd_calculator_cpu_step dut (.*);

	bcd_step_checker checker_i (.*);

	// receiver stall pattern: phases of none, light, heavy stalling
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_step(logic [10:0] w, logic kn, logic ko, logic [3:0] pos);
		in_valid <= 1'b1;
		instr_word <= w;
		key_n <= kn;
		key_o <= ko;
		read_position <= pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		steps_sent++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_variant(logic v);
		variant_we <= 1'b1;
		variant_wdata <= v;
		@(posedge clk);
		variant_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly digit and flag work, with branches and key waits mixed in
	function automatic logic [10:0] random_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return {CLS_DIGIT, 9'($urandom)};
		if (sel < 7) return {CLS_MISC, 1'b1, 8'($urandom)};
		if (sel < 8) return {CLS_MISC, 1'b0, 8'($urandom)};
		return {1'b0, 10'($urandom)};
	endfunction

	task automatic random_phase(int count);
		int burst;
		int n;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < count; b++, n++)
				send_step(random_word(), 1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: constant copy and add, the alternate-variant digit opcodes, then flag, branch and key words
		for (int v = 0; v < 2; v++) begin
			write_variant(v[0]);
			send_step({CLS_DIGIT, OP_CPY_K_A, 4'd15}, 1'b0, 1'b0, 4'd0);
			send_step({CLS_DIGIT, OP_ADD_AK_A, 4'd0}, 1'b0, 1'b0, 4'd10);
			send_step({CLS_DIGIT, OP_ALT27, 4'd8}, 1'b1, 1'b1, 4'd15);
			send_step({CLS_DIGIT, OP_ALT28, 4'd15}, 1'b0, 1'b1, 4'd11);
			send_step({CLS_DIGIT, OP_ALT30, 4'd0}, 1'b1, 1'b0, 4'd5);
			send_step({CLS_DIGIT, OP_ALT31, 4'd11}, 1'b0, 1'b0, 4'd8);
			send_step({CLS_DIGIT, OP_ALT3, 4'd12}, 1'b0, 1'b0, 4'd0);
			send_step({CLS_MISC, FOP_SET_A, 4'd15}, 1'b0, 1'b0, 4'd1);
			send_step({CLS_MISC, FOP_CMP, 4'd15}, 1'b0, 1'b0, 4'd2);
			send_step({CLS_BR_C, 9'h1FF}, 1'b0, 1'b0, 4'd3);
			send_step({CLS_MISC, 2'b00, 7'h7F}, 1'b0, 1'b1, 4'd4);
			send_step({CLS_MISC, 2'b01, 7'h00}, 1'b1, 1'b1, 4'd9);
			drain();
		end
		write_variant(1'b0);
		random_phase(800);
		// sender holds off until all results are in before the variant change
		drain();
		write_variant(1'b1);
		random_phase(800);
		drain();
		write_variant(1'b0);
		random_phase(100);
		drain();
		$display("sent %0d instruction steps over both variants, with sender gaps and", steps_sent);
		$display("receiver stall phases; every result checked field by field");
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
